// ===== rtl/tuv_pkg.sv =====
// ----------------------------------------------------------------------------
// tuv_pkg: shared types, widths and helpers for the triangle tangent block
// Holds the vertex record, the sequencer state codes, the control and status
// bundles between the sequencer and its arithmetic units, and the output
// saturation.
// ----------------------------------------------------------------------------
package tuv_pkg;

  // field widths of the request and result
  localparam int POS_W  = 32;
  localparam int UV_W   = 16;
  localparam int TAN_W  = 32;

  // datapath widths
  localparam int DU_W   = UV_W + 1;        // uv delta
  localparam int E_W    = POS_W + 1;       // position edge
  localparam int PROD_W = DU_W + E_W;      // one product of the mac
  localparam int ACC_W  = PROD_W + 1;      // difference of two products
  localparam int AN_W   = ACC_W;           // numerator magnitude
  localparam int AD_W   = 35;              // determinant magnitude
  localparam int QW     = TAN_W;           // quotient bits produced per divide
  localparam int CNT_W  = $clog2(QW);

  // corners held before the closing one
  localparam logic [1:0] CORNERS_OPEN = 2'd2;
  localparam logic [1:0] LAST_COMP    = 2'd2;

  localparam logic [TAN_W-1:0] SAT_POS = {1'b0, {(TAN_W-1){1'b1}}};
  localparam logic [TAN_W-1:0] SAT_NEG = {1'b1, {(TAN_W-1){1'b0}}};

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic signed [UV_W-1:0]  tex_u;
    logic signed [UV_W-1:0]  tex_v;
  } vtx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIFF,
    ST_DET1,
    ST_DET2,
    ST_DET3,
    ST_DETABS,
    ST_DETCHK,
    ST_E1,
    ST_E2,
    ST_M2,
    ST_NUMS,
    ST_ABS,
    ST_PREP,
    ST_DIV,
    ST_STORE,
    ST_OUT
  } st_e;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_SUB,
    ACC_ABS
  } acc_op_e;

  typedef struct packed {
    logic    mul_en;
    acc_op_e acc_op;
  } mac_ctl_t;

  typedef struct packed {
    logic busy;
    logic ovf;
  } div_sts_t;

  // position component of a vertex, by component index
  function automatic logic signed [POS_W-1:0] pos_sel(input vtx_t v, input logic [1:0] k);
    logic signed [POS_W-1:0] p;
    unique case (k)
      2'd0:    p = v.pos_x;
      2'd1:    p = v.pos_y;
      default: p = v.pos_z;
    endcase
    return p;
  endfunction

  // signed, saturated tangent component from quotient magnitude
  function automatic logic [TAN_W-1:0] sat_tan(input logic [QW-1:0] q, input logic ovf,
                                               input logic neg);
    logic [TAN_W-1:0] r;
    priority if (ovf) begin
      r = neg ? SAT_NEG : SAT_POS;
    end else if (neg) begin
      r = (q > SAT_NEG) ? SAT_NEG : TAN_W'(~q + 1'b1);
    end else begin
      r = q[QW-1] ? SAT_POS : q;
    end
    return r;
  endfunction

endpackage

// ===== rtl/tuv_if.sv =====
// ----------------------------------------------------------------------------
// tuv_if: valid/ready channels of the triangle tangent block
// One channel carries vertices in, the other carries tangents out.
// ----------------------------------------------------------------------------
interface tuv_vtx_if;
  import tuv_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic signed [POS_W-1:0] pos_z;
  logic signed [UV_W-1:0]  tex_u;
  logic signed [UV_W-1:0]  tex_v;

  modport source (output valid, pos_x, pos_y, pos_z, tex_u, tex_v, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, tex_u, tex_v, output ready);
endinterface

interface tuv_tan_if;
  import tuv_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [TAN_W-1:0] tangent_x;
  logic signed [TAN_W-1:0] tangent_y;
  logic signed [TAN_W-1:0] tangent_z;
  logic                    degenerate;

  modport source (output valid, tangent_x, tangent_y, tangent_z, degenerate, input ready);
  modport sink   (input valid, tangent_x, tangent_y, tangent_z, degenerate, output ready);
endinterface

// ===== rtl/tuv_mac.sv =====
// ----------------------------------------------------------------------------
// tuv_mac: shared multiply-accumulate unit
// A registered 17x33 signed multiplier feeding an accumulator that can load,
// subtract or take the magnitude. Used for the determinant and numerators.
// ----------------------------------------------------------------------------
module tuv_mac (
  input  logic                            clk_i,
  input  tuv_pkg::mac_ctl_t               ctl_i,
  input  logic signed [tuv_pkg::DU_W-1:0] op_a_i,
  input  logic signed [tuv_pkg::E_W-1:0]  op_b_i,
  output logic signed [tuv_pkg::ACC_W-1:0] acc_o
);
  import tuv_pkg::*;

  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [ACC_W-1:0]  acc_d;

  // product of the two operands
  assign prod = PROD_W'(op_a_i) * PROD_W'(op_b_i);

  // accumulator update
  always_comb begin
    unique case (ctl_i.acc_op)
      ACC_LOAD: acc_d = ACC_W'(prod_q);
      ACC_SUB:  acc_d = acc_q - ACC_W'(prod_q);
      ACC_ABS:  acc_d = acc_q[ACC_W-1] ? -acc_q : acc_q;
      default:  acc_d = acc_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.mul_en) begin
      prod_q <= prod;
    end
    acc_q <= acc_d;
  end

  assign acc_o = acc_q;

endmodule

// ===== rtl/tuv_div.sv =====
// ----------------------------------------------------------------------------
// tuv_div: radix-2 restoring divider for the scaled quotient
// Divides the numerator magnitude, scaled up by the uv fraction bits, by the
// determinant magnitude. Checks for a quotient beyond 32 bits on start, then,
// unless it overflows, produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tuv_div #(
  parameter int UV_FRAC_BITS = 12
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [tuv_pkg::AN_W-1:0]    an_i,
  input  logic [tuv_pkg::AD_W-1:0]    ad_i,
  output tuv_pkg::div_sts_t           sts_o,
  output logic [tuv_pkg::QW-1:0]      quo_o
);
  import tuv_pkg::*;

  localparam int DW    = AN_W + UV_FRAC_BITS;
  localparam int HI_W  = DW - QW;
  localparam int CMP_W = (HI_W > AD_W) ? HI_W : AD_W;

  logic [DW-1:0]    dvd;
  logic [HI_W-1:0]  hi;
  logic             ovf;
  logic [AD_W:0]    trial;
  logic             ge;
  logic [AD_W-1:0]  rem_q;
  logic [QW-1:0]    quo_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             ovf_q;

  // scaled dividend and the overflow check on its upper part
  assign dvd = {an_i, {UV_FRAC_BITS{1'b0}}};
  assign hi  = dvd[DW-1:QW];
  assign ovf = CMP_W'(hi) >= CMP_W'(ad_i);

  // one compare-subtract step
  assign trial = {rem_q, quo_q[QW-1]};
  assign ge    = trial >= {1'b0, ad_i};

  // step control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      ovf_q  <= 1'b0;
    end else if (start_i) begin
      busy_q <= !ovf;
      cnt_q  <= '0;
      ovf_q  <= ovf;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CNT_W'(QW - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  // partial remainder and dividend/quotient shift register
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= AD_W'(hi);
      quo_q <= dvd[QW-1:0];
    end else if (busy_q) begin
      rem_q <= ge ? AD_W'(trial - {1'b0, ad_i}) : trial[AD_W-1:0];
      quo_q <= {quo_q[QW-2:0], ge};
    end
  end

  assign sts_o.busy = busy_q;
  assign sts_o.ovf  = ovf_q;
  assign quo_o      = quo_q;

endmodule

// ===== rtl/triangle_tangent_from_uv_top.sv =====
// Per-triangle tangent from positions and texture coordinates. Vertices come
// in one request at a time; every third one closes a triangle and yields one
// tangent (Q16.16, saturated, truncated toward zero), or a zero tangent with
// the degenerate flag when the uv determinant is zero. The first two corners
// are only stored. The closing corner starts a sequence: the determinant on
// the shared 17x33 multiply-accumulate unit, then per component the edges,
// numerator and divider setup and the 32 steps of the radix-2 divider (a
// quotient beyond 32 bits skips the steps). A degenerate triangle goes from
// the determinant check straight to the output. A finished tangent waits in
// the output register while the next triangle is collected.
// ----------------------------------------------------------------------------
// triangle_tangent_from_uv_top: triangle tangent block, top level
// Holds the corners, sequences the shared mac and divider and registers the
// result.
// ----------------------------------------------------------------------------
module triangle_tangent_from_uv_top #(
  parameter int UV_FRAC_BITS = 12
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  tuv_vtx_if.sink          vtx_i,
  tuv_tan_if.source        tan_o
);
  import tuv_pkg::*;

  st_e                     state_q, state_d;
  logic [1:0]              corner_q;
  logic [1:0]              comp_q;
  logic                    out_vld_q;

  vtx_t                    vtx_in;
  vtx_t                    held_q [2];
  vtx_t                    c_q;
  logic signed [DU_W-1:0]  d1u_q, d1v_q, d2u_q, d2v_q;
  logic signed [E_W-1:0]   e_q;
  logic signed [POS_W-1:0] e_lhs;
  logic [AD_W-1:0]         ad_q;
  logic                    det_neg_q, det_zero_q, neg_q;
  logic [TAN_W-1:0]        res_q [3];
  logic [TAN_W-1:0]        out_x_q, out_y_q, out_z_q;
  logic                    out_deg_q;

  // sequencer controls
  logic                    vtx_take;
  logic                    diff_en, e_en, e_sel_c, det_en, ad_en, neg_en;
  logic                    comp_clr, res_en, out_load;
  logic                    div_start;
  mac_ctl_t                mac_ctl;
  logic signed [DU_W-1:0]  op_a;
  logic signed [E_W-1:0]   op_b;
  logic signed [ACC_W-1:0] acc;
  div_sts_t                div_sts;
  logic [QW-1:0]           quo;

  assign vtx_in = '{pos_x: vtx_i.pos_x, pos_y: vtx_i.pos_y, pos_z: vtx_i.pos_z,
                    tex_u: vtx_i.tex_u, tex_v: vtx_i.tex_v};

  assign vtx_i.ready = (state_q == ST_IDLE);
  assign vtx_take    = vtx_i.valid && vtx_i.ready;

  // shared arithmetic units
  tuv_mac u_mac (
    .clk_i  (clk_i),
    .ctl_i  (mac_ctl),
    .op_a_i (op_a),
    .op_b_i (op_b),
    .acc_o  (acc)
  );

  tuv_div #(
    .UV_FRAC_BITS (UV_FRAC_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .an_i    (acc[AN_W-1:0]),
    .ad_i    (ad_q),
    .sts_o   (div_sts),
    .quo_o   (quo)
  );

  // next state and unit controls
  always_comb begin
    state_d   = state_q;
    diff_en   = 1'b0;
    e_en      = 1'b0;
    e_sel_c   = 1'b0;
    det_en    = 1'b0;
    ad_en     = 1'b0;
    neg_en    = 1'b0;
    comp_clr  = 1'b0;
    res_en    = 1'b0;
    out_load  = 1'b0;
    div_start = 1'b0;
    mac_ctl   = '{mul_en: 1'b0, acc_op: ACC_HOLD};
    op_a      = d2v_q;
    op_b      = e_q;
    unique case (state_q)
      ST_IDLE: begin
        if (vtx_take && corner_q == CORNERS_OPEN) begin
          state_d = ST_DIFF;
        end
      end
      ST_DIFF: begin
        diff_en = 1'b1;
        state_d = ST_DET1;
      end
      ST_DET1: begin
        op_a           = d1u_q;
        op_b           = E_W'(d2v_q);
        mac_ctl.mul_en = 1'b1;
        state_d        = ST_DET2;
      end
      ST_DET2: begin
        op_a           = d2u_q;
        op_b           = E_W'(d1v_q);
        mac_ctl.mul_en = 1'b1;
        mac_ctl.acc_op = ACC_LOAD;
        state_d        = ST_DET3;
      end
      ST_DET3: begin
        mac_ctl.acc_op = ACC_SUB;
        state_d        = ST_DETABS;
      end
      ST_DETABS: begin
        mac_ctl.acc_op = ACC_ABS;
        det_en         = 1'b1;
        state_d        = ST_DETCHK;
      end
      ST_DETCHK: begin
        ad_en    = 1'b1;
        comp_clr = 1'b1;
        state_d  = det_zero_q ? ST_OUT : ST_E1;
      end
      ST_E1: begin
        e_en    = 1'b1;
        state_d = ST_E2;
      end
      ST_E2: begin
        op_a           = d2v_q;
        op_b           = e_q;
        mac_ctl.mul_en = 1'b1;
        e_en           = 1'b1;
        e_sel_c        = 1'b1;
        state_d        = ST_M2;
      end
      ST_M2: begin
        op_a           = d1v_q;
        op_b           = e_q;
        mac_ctl.mul_en = 1'b1;
        mac_ctl.acc_op = ACC_LOAD;
        state_d        = ST_NUMS;
      end
      ST_NUMS: begin
        mac_ctl.acc_op = ACC_SUB;
        state_d        = ST_ABS;
      end
      ST_ABS: begin
        mac_ctl.acc_op = ACC_ABS;
        neg_en         = 1'b1;
        state_d        = ST_PREP;
      end
      ST_PREP: begin
        div_start = 1'b1;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        if (!div_sts.busy) begin
          state_d = ST_STORE;
        end
      end
      ST_STORE: begin
        res_en  = 1'b1;
        state_d = (comp_q == LAST_COMP) ? ST_OUT : ST_E1;
      end
      ST_OUT: begin
        if (!out_vld_q || tan_o.ready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      corner_q  <= '0;
      comp_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (vtx_take) begin
        corner_q <= (corner_q == CORNERS_OPEN) ? 2'd0 : corner_q + 1'b1;
      end
      if (comp_clr) begin
        comp_q <= '0;
      end else if (res_en) begin
        comp_q <= comp_q + 1'b1;
      end
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (tan_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // edge operand from the shared subtractor
  assign e_lhs = e_sel_c ? pos_sel(c_q, comp_q) : pos_sel(held_q[1], comp_q);

  // corner store, deltas, edges and result registers
  always_ff @(posedge clk_i) begin
    if (vtx_take) begin
      if (corner_q == CORNERS_OPEN) begin
        c_q <= vtx_in;
      end else begin
        held_q[corner_q[0]] <= vtx_in;
      end
    end
    if (diff_en) begin
      d1u_q <= DU_W'(held_q[1].tex_u) - DU_W'(held_q[0].tex_u);
      d1v_q <= DU_W'(held_q[1].tex_v) - DU_W'(held_q[0].tex_v);
      d2u_q <= DU_W'(c_q.tex_u) - DU_W'(held_q[0].tex_u);
      d2v_q <= DU_W'(c_q.tex_v) - DU_W'(held_q[0].tex_v);
    end
    if (e_en) begin
      e_q <= E_W'(e_lhs) - E_W'(pos_sel(held_q[0], comp_q));
    end
    if (det_en) begin
      det_neg_q  <= acc[ACC_W-1];
      det_zero_q <= (acc == '0);
    end
    if (ad_en) begin
      ad_q <= acc[AD_W-1:0];
    end
    if (neg_en) begin
      neg_q <= acc[ACC_W-1] ^ det_neg_q;
    end
    if (res_en) begin
      unique case (comp_q)
        2'd0:    res_q[0] <= sat_tan(quo, div_sts.ovf, neg_q);
        2'd1:    res_q[1] <= sat_tan(quo, div_sts.ovf, neg_q);
        default: res_q[2] <= sat_tan(quo, div_sts.ovf, neg_q);
      endcase
    end
    if (out_load) begin
      out_x_q   <= det_zero_q ? '0 : res_q[0];
      out_y_q   <= det_zero_q ? '0 : res_q[1];
      out_z_q   <= det_zero_q ? '0 : res_q[2];
      out_deg_q <= det_zero_q;
    end
  end

  assign tan_o.valid      = out_vld_q;
  assign tan_o.tangent_x  = out_x_q;
  assign tan_o.tangent_y  = out_y_q;
  assign tan_o.tangent_z  = out_z_q;
  assign tan_o.degenerate = out_deg_q;

`ifndef ASSERT_OFF
  // a result only appears out of the output state
  a_out_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(state_q == ST_OUT))
    else $error("result raised outside the output state");

  // degenerate triangles give a zero tangent
  a_deg_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_deg_q |-> (out_x_q == '0 && out_y_q == '0 && out_z_q == '0))
    else $error("degenerate result with non-zero tangent");

  // divider is never restarted mid-division
  a_div_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_sts.busy)
    else $error("divider started while busy");

  // divisor holds while the divider steps
  a_div_ad_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_sts.busy |=> $stable(ad_q))
    else $error("divisor changed during division");
`endif

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench for the triangle tangent block
// Sends vertex requests through the valid/ready channels and checks every
// tangent against a typed-in one or its own predictor. A short table of directed
// triangles comes first, then random triangles under three patterns of idling.
// ----------------------------------------------------------------------------
module tb;
  import tuv_pkg::*;

  localparam int UVF         = 12;
  localparam int TRIANGLES   = 150;
  localparam int TAIL_CYCLES = 200;
  localparam int CYCLE_LIMIT = 300000;

  typedef struct packed {
    logic signed [TAN_W-1:0] tangent_x;
    logic signed [TAN_W-1:0] tangent_y;
    logic signed [TAN_W-1:0] tangent_z;
    logic                    degenerate;
  } tangent_t;

  // one vertex request, with a typed-in tangent where the corner closes one
  typedef struct packed {
    vtx_t     v;
    logic     fixed;
    tangent_t t;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;

  tuv_vtx_if vtx ();
  tuv_tan_if tan ();

  triangle_tangent_from_uv_top #(
    .UV_FRAC_BITS(UVF)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .vtx_i (vtx),
    .tan_o (tan)
  );

  always #1 clk_i = ~clk_i;

  // corners held by the predictor
  longint      held_pos [2][3];
  longint      held_u [2];
  longint      held_v [2];
  int unsigned corners_held;

  tangent_t    tangents_due [$];
  stim_row_t   dir_rows [$];
  tangent_t    oldest_due;
  int unsigned gap_pct;
  int unsigned stall_pct;
  int unsigned mismatches;
  int unsigned cycle_count;

  // num * 2^UVF / det, truncated toward zero, saturated to the tangent range
  function automatic logic [TAN_W-1:0] scaled_quotient(input longint num, input longint det);
    logic             neg;
    logic [127:0]     an;
    logic [127:0]     ad;
    logic [127:0]     mag;
    logic [TAN_W-1:0] r;
    neg = (num < 0) != (det < 0);
    an  = (num < 0) ? -num : num;
    ad  = (det < 0) ? -det : det;
    mag = (an << UVF) / ad;
    if (neg) begin
      r = (mag >= 128'h8000_0000) ? SAT_NEG : -mag[TAN_W-1:0];
    end else begin
      r = (mag > 128'h7FFF_FFFF) ? SAT_POS : mag[TAN_W-1:0];
    end
    return r;
  endfunction

  // takes one corner; returns 1 with the tangent when it closes a triangle
  function automatic bit tangent_after_corner(input vtx_t c, output tangent_t t);
    longint           cp [3];
    longint           d1u, d1v, d2u, d2v, det, e1, e2;
    logic [TAN_W-1:0] q [3];
    int               k;
    cp[0] = c.pos_x;
    cp[1] = c.pos_y;
    cp[2] = c.pos_z;
    t = '0;
    if (corners_held < CORNERS_OPEN) begin
      held_pos[corners_held] = cp;
      held_u[corners_held]   = c.tex_u;
      held_v[corners_held]   = c.tex_v;
      corners_held++;
      return 1'b0;
    end
    corners_held = 0;
    d1u = held_u[1] - held_u[0];
    d1v = held_v[1] - held_v[0];
    d2u = longint'(c.tex_u) - held_u[0];
    d2v = longint'(c.tex_v) - held_v[0];
    det = d1u * d2v - d2u * d1v;
    if (det == 0) begin
      t.degenerate = 1'b1;
      return 1'b1;
    end
    for (k = 0; k < 3; k++) begin
      e1   = held_pos[1][k] - held_pos[0][k];
      e2   = cp[k] - held_pos[0][k];
      q[k] = scaled_quotient(d2v * e1 - d1v * e2, det);
    end
    t.tangent_x = q[0];
    t.tangent_y = q[1];
    t.tangent_z = q[2];
    return 1'b1;
  endfunction

  // directed table entries
  task automatic add_corner(input logic [POS_W-1:0] px, input logic [POS_W-1:0] py,
                            input logic [POS_W-1:0] pz, input logic [UV_W-1:0] u,
                            input logic [UV_W-1:0] v);
    stim_row_t r;
    r          = '0;
    r.v.pos_x  = px;
    r.v.pos_y  = py;
    r.v.pos_z  = pz;
    r.v.tex_u  = u;
    r.v.tex_v  = v;
    dir_rows.insert(dir_rows.size(), r);
  endtask

  task automatic closes_to(input logic [TAN_W-1:0] tx, input logic [TAN_W-1:0] ty,
                           input logic [TAN_W-1:0] tz, input logic deg);
    stim_row_t r;
    int        n;
    n                = dir_rows.size() - 1;
    r                = dir_rows[n];
    r.fixed          = 1'b1;
    r.t.tangent_x    = tx;
    r.t.tangent_y    = ty;
    r.t.tangent_z    = tz;
    r.t.degenerate   = deg;
    dir_rows[n]      = r;
  endtask

  // drive one request, wait for acceptance, then record what it should yield
  task automatic send_vertex(input stim_row_t row);
    tangent_t t;
    while ($urandom_range(99) < gap_pct) begin
      vtx.valid <= 1'b0;
      @(posedge clk_i);
    end
    vtx.valid <= 1'b1;
    vtx.pos_x <= row.v.pos_x;
    vtx.pos_y <= row.v.pos_y;
    vtx.pos_z <= row.v.pos_z;
    vtx.tex_u <= row.v.tex_u;
    vtx.tex_v <= row.v.tex_v;
    @(posedge clk_i);
    while (!vtx.ready) @(posedge clk_i);
    if (tangent_after_corner(row.v, t))
      tangents_due.insert(tangents_due.size(), row.fixed ? row.t : t);
  endtask

  task automatic report_field(input string field, input logic [TAN_W-1:0] want,
                              input logic [TAN_W-1:0] got);
    $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
    mismatches++;
  endtask

  // result side: check each accepted tangent, then stall at random
  always @(posedge clk_i) begin
    if (tan.valid && tan.ready) begin
      if (tangents_due.size() == 0) begin
        $display("%0t: unexpected tangent, expected none, got %h %h %h %b", $time,
                 tan.tangent_x, tan.tangent_y, tan.tangent_z, tan.degenerate);
        mismatches++;
      end else begin
        oldest_due = tangents_due.pop_front();
        if (oldest_due.tangent_x !== tan.tangent_x)
          report_field("tangent_x", oldest_due.tangent_x, tan.tangent_x);
        if (oldest_due.tangent_y !== tan.tangent_y)
          report_field("tangent_y", oldest_due.tangent_y, tan.tangent_y);
        if (oldest_due.tangent_z !== tan.tangent_z)
          report_field("tangent_z", oldest_due.tangent_z, tan.tangent_z);
        if (oldest_due.degenerate !== tan.degenerate)
          report_field("degenerate", TAN_W'(oldest_due.degenerate), TAN_W'(tan.degenerate));
      end
    end
    tan.ready <= ($urandom_range(99) >= stall_pct);
  end

  // run limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  // stimulus
  initial begin
    stim_row_t   row;
    vtx_t        first;
    vtx_t        second;
    int unsigned mode;
    int          i;
    int          c;

    clk_i        = 1'b0;
    rst_ni       = 1'b0;
    vtx.valid    = 1'b0;
    vtx.pos_x    = '0;
    vtx.pos_y    = '0;
    vtx.pos_z    = '0;
    vtx.tex_u    = '0;
    vtx.tex_v    = '0;
    tan.ready    = 1'b0;
    gap_pct      = 10;
    stall_pct    = 61;
    corners_held = 0;
    mismatches   = 0;
    first        = '0;
    second       = '0;

    // all corners zero: zero determinant
    add_corner(32'h0, 32'h0, 32'h0, 16'h0, 16'h0);
    add_corner(32'h0, 32'h0, 32'h0, 16'h0, 16'h0);
    add_corner(32'h0, 32'h0, 32'h0, 16'h0, 16'h0);
    closes_to(32'h0, 32'h0, 32'h0, 1'b1);
    // unit triangle: tangent of one along x
    add_corner(32'h0, 32'h0, 32'h0, 16'h0, 16'h0);
    add_corner(32'h0001_0000, 32'h0, 32'h0, 16'h1000, 16'h0);
    add_corner(32'h0, 32'h0001_0000, 32'h0, 16'h0, 16'h1000);
    closes_to(32'h0001_0000, 32'h0, 32'h0, 1'b0);
    // determinant of one with extreme edges: saturation both ways
    add_corner(32'h0, 32'h0, 32'h0, 16'h0, 16'h0);
    add_corner(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 16'h1, 16'h0);
    add_corner(32'h0000_3039, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 16'h0, 16'h1);
    closes_to(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 1'b0);
    // extremes of every field
    add_corner(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 16'h8000, 16'h8000);
    add_corner(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 16'h7FFF, 16'h8000);
    add_corner(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'h8000, 16'h7FFF);
    // collinear uvs with non-zero positions
    add_corner(32'h0012_3456, 32'hFFF0_0000, 32'h0000_0100, 16'h0, 16'h0);
    add_corner(32'h0100_0000, 32'h0000_ABCD, 32'hFF00_0000, 16'd100, 16'd200);
    add_corner(32'hFFFF_0000, 32'h0200_0000, 32'h0000_7777, 16'd200, 16'd400);
    closes_to(32'h0, 32'h0, 32'h0, 1'b1);
    // quotients with a fraction, truncated toward zero on both signs
    add_corner(32'h0, 32'h0, 32'h0, 16'h0, 16'h0);
    add_corner(32'h1, 32'hFFFF_FFFF, 32'h7, 16'd3, 16'd1);
    add_corner(32'h2, 32'h5, 32'hFFFF_FFFB, 16'd0, 16'd3);
    // negative determinant
    add_corner(32'h0, 32'h0, 32'h0, 16'h0, 16'h0);
    add_corner(32'h0, 32'h0001_0000, 32'h0, 16'h0, 16'h1000);
    add_corner(32'h0001_0000, 32'h0, 32'h0, 16'h1000, 16'h0);
    // exactly the most negative tangent, one below and one above the top
    add_corner(32'h0, 32'h0, 32'h0, 16'h0, 16'h0);
    add_corner(32'hFFF8_0000, 32'h0007_FFFF, 32'h0008_0000, 16'h1, 16'h0);
    add_corner(32'h0, 32'h0, 32'h0, 16'h0, 16'h1);
    closes_to(32'h8000_0000, 32'h7FFF_F000, 32'h7FFF_FFFF, 1'b0);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[n]) send_vertex(dir_rows[n]);

    // random triangles, idling pattern changes by thirds
    for (i = 0; i < TRIANGLES; i++) begin
      if (i == TRIANGLES / 3) begin
        gap_pct   = 61;
        stall_pct = 10;
      end else if (i == 2 * TRIANGLES / 3) begin
        gap_pct   = 0;
        stall_pct = 0;
      end
      // 0-2 full range, 3-6 shorter edges, 7 degenerate, 8-9 tiny uv deltas
      mode = $urandom_range(9);
      for (c = 0; c < 3; c++) begin
        row         = '0;
        row.v.pos_x = $urandom;
        row.v.pos_y = $urandom;
        row.v.pos_z = $urandom;
        row.v.tex_u = UV_W'($urandom);
        row.v.tex_v = UV_W'($urandom);
        if (mode >= 3 && mode != 7) begin
          row.v.pos_x = row.v.pos_x >>> $urandom_range(4, 28);
          row.v.pos_y = row.v.pos_y >>> $urandom_range(4, 28);
          row.v.pos_z = row.v.pos_z >>> $urandom_range(4, 28);
        end
        if (mode >= 8 && c != 0) begin
          row.v.tex_u = first.tex_u + UV_W'($urandom_range(0, 31)) - UV_W'(16);
          row.v.tex_v = first.tex_v + UV_W'($urandom_range(0, 31)) - UV_W'(16);
        end
        if (mode == 7 && c == 2) begin
          if ($urandom_range(1) == 1) begin
            row.v.tex_u = first.tex_u;
            row.v.tex_v = first.tex_v;
          end else begin
            row.v.tex_u = second.tex_u;
            row.v.tex_v = second.tex_v;
          end
        end
        if (c == 0) first = row.v;
        else if (c == 1) second = row.v;
        send_vertex(row);
      end
    end
    vtx.valid <= 1'b0;

    // drain, then watch for stray results
    while (tangents_due.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/tuv_pkg.sv
rtl/tuv_if.sv
rtl/tuv_mac.sv
rtl/tuv_div.sv
rtl/triangle_tangent_from_uv_top.sv
sim/tb.sv
